>>> rtl/core/ppsched_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package ppsched_pkg;

  localparam int KIND_W     = 2;
  localparam int ARR_W      = 12;
  localparam int BUR_W      = 12;
  localparam int PRI_W      = 8;
  localparam int TIME_W     = 17;
  localparam int SUM_W      = 21;
  localparam int SLOT_OUT_W = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [TIME_W-1:0] CLOCK_MAX = 17'h1FFFF;
  localparam logic [SUM_W-1:0]  TOTAL_MAX = 21'h1FFFFF;

  typedef struct packed {
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [BUR_W-1:0] remaining;
    logic [PRI_W-1:0] prio;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  typedef struct packed {
    logic start;
    logic cmp_en;
  } pick_ctl_t;

endpackage

>>> rtl/core/ppsched_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ppsched_pick.sv
// Shared compare unit: keeps the best ready job seen during a table scan.
module ppsched_pick import ppsched_pkg::*; #(
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pick_ctl_t         ctl,
  input  logic [TIME_W-1:0] now,
  input  job_t              entry,
  input  logic [AW-1:0]     idx,
  output logic              found,
  output logic [AW-1:0]     slot,
  output job_t              best
);

  logic    found_r;
  logic [AW-1:0] slot_r;
  job_t    best_r;
  logic    eligible;
  logic    better;
  logic    take;

  assign eligible = (TIME_W'(entry.arrival) <= now) && (entry.remaining != '0);
  assign better   = !found_r || (entry.prio < best_r.prio) ||
                    ((entry.prio == best_r.prio) && (entry.arrival < best_r.arrival));
  assign take     = ctl.cmp_en && eligible && better;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_r <= idx;
      best_r <= entry;
    end
  end

  assign found = found_r;
  assign slot  = slot_r;
  assign best  = best_r;

endmodule

>>> rtl/core/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler top level: job table, scan sequencer, result register.
// Load, clear and unknown items go straight to the result push; a tick scans the loaded
// jobs, then updates, adds the finish and total steps when a job finishes, then pushes.
// The scan reads one table entry per cycle into one shared compare unit.
// One request at a time: in_tready is high only in idle, so a new request is taken only
// after the previous result is pushed, later while out_tready holds back the result still held in the output register.
// rst_n (synchronous, active low) clears counters, clock, totals and control; no RAM clear.
module preemptive_priority_scheduler_top import ppsched_pkg::*; #(
  parameter int MAX_JOBS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // arrival_time[11:0], burst_length[23:12], job_priority[31:24]
  input  logic [1:0]    in_tuser,   // kind[1:0]
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [119:0]  out_tdata   // ran_valid[0], ran_slot[4:1], finished[5],
                                    // completion_time[22:6], turnaround[39:23],
                                    // waiting[56:40], all_done[57], turnaround_sum[78:58],
                                    // waiting_sum[99:79], now[116:100], zero[119:117]
);

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_TOT  = 3'd4;
  localparam logic [2:0] S_PUSH = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]     fin_cnt_r, fin_cnt_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SUM_W-1:0]  tsum_r, tsum_nxt;
  logic [SUM_W-1:0]  wsum_r, wsum_nxt;
  logic [CW-1:0]     issue_r, issue_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;

  logic              ran_r, ran_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic              fin_r, fin_nxt;
  logic [TIME_W-1:0] ct_r, ct_nxt;
  logic [TIME_W-1:0] tat_r, tat_nxt;
  logic [TIME_W-1:0] wt_r, wt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [119:0]      out_data_r, out_data_nxt;

  logic              in_fire;
  logic [KIND_W-1:0] in_kind;
  logic [ARR_W-1:0]  in_arr;
  logic [BUR_W-1:0]  in_bur;
  logic [PRI_W-1:0]  in_pri;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  job_t              ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [JOB_W-1:0]  ram_rdata;

  pick_ctl_t         pick_ctl;
  logic              best_found;
  logic [AW-1:0]     best_slot;
  job_t              best_job;

  logic [TIME_W-1:0] now_inc;
  logic [SUM_W:0]    tsum_add;
  logic [SUM_W:0]    wsum_add;
  logic [TIME_W-1:0] bur_ext;

  assign in_kind   = in_tuser[1:0];
  assign in_arr    = in_tdata[11:0];
  assign in_bur    = in_tdata[23:12];
  assign in_pri    = in_tdata[31:24];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign now_inc  = (now_r == CLOCK_MAX) ? now_r : now_r + TIME_W'(1);
  assign tsum_add = {1'b0, tsum_r} + (SUM_W + 1)'(tat_r);
  assign wsum_add = {1'b0, wsum_r} + (SUM_W + 1)'(wt_r);
  assign bur_ext  = TIME_W'(best_job.burst);

  assign ram_raddr = issue_r[AW-1:0];

  ppsched_ram #(
    .WIDTH (JOB_W),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ppsched_pick #(
    .AW (AW)
  ) u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pick_ctl),
    .now   (now_r),
    .entry (job_t'(ram_rdata)),
    .idx   (cmp_idx_r),
    .found (best_found),
    .slot  (best_slot),
    .best  (best_job)
  );

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    fin_cnt_nxt   = fin_cnt_r;
    now_nxt       = now_r;
    tsum_nxt      = tsum_r;
    wsum_nxt      = wsum_r;
    issue_nxt     = issue_r;
    rd_pend_nxt   = rd_pend_r;
    cmp_idx_nxt   = cmp_idx_r;
    ran_nxt       = ran_r;
    slot_nxt      = slot_r;
    fin_nxt       = fin_r;
    ct_nxt        = ct_r;
    tat_nxt       = tat_r;
    wt_nxt        = wt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = load_cnt_r[AW-1:0];
    ram_wdata     = '{arrival: in_arr, burst: in_bur, remaining: in_bur, prio: in_pri};
    pick_ctl      = '{start: 1'b0, cmp_en: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ran_nxt   = 1'b0;
          slot_nxt  = '0;
          fin_nxt   = 1'b0;
          ct_nxt    = '0;
          tat_nxt   = '0;
          wt_nxt    = '0;
          state_nxt = S_PUSH;
          unique case (in_kind)
            KIND_LOAD: begin
              if ((load_cnt_r != CW'(MAX_JOBS)) && (in_bur != '0)) begin
                ram_we       = 1'b1;
                load_cnt_nxt = load_cnt_r + CW'(1);
              end
            end
            KIND_TICK: begin
              issue_nxt      = '0;
              rd_pend_nxt    = 1'b0;
              pick_ctl.start = 1'b1;
              state_nxt      = S_SCAN;
            end
            KIND_CLEAR: begin
              load_cnt_nxt = '0;
              fin_cnt_nxt  = '0;
              now_nxt      = '0;
              tsum_nxt     = '0;
              wsum_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        pick_ctl.cmp_en = rd_pend_r;
        if (issue_r != load_cnt_r) begin
          issue_nxt   = issue_r + CW'(1);
          rd_pend_nxt = 1'b1;
          cmp_idx_nxt = issue_r[AW-1:0];
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        now_nxt   = now_inc;
        state_nxt = S_PUSH;
        if (best_found) begin
          ram_we              = 1'b1;
          ram_waddr           = best_slot;
          ram_wdata           = best_job;
          ram_wdata.remaining = best_job.remaining - BUR_W'(1);
          ran_nxt             = 1'b1;
          slot_nxt            = best_slot;
          if (best_job.remaining == BUR_W'(1)) begin
            fin_nxt     = 1'b1;
            ct_nxt      = now_inc;
            tat_nxt     = now_inc - TIME_W'(best_job.arrival);
            fin_cnt_nxt = fin_cnt_r + CW'(1);
            state_nxt   = S_FIN;
          end
        end
      end
      S_FIN: begin
        wt_nxt    = (tat_r > bur_ext) ? tat_r - bur_ext : '0;
        tsum_nxt  = (tsum_add > (SUM_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : tsum_add[SUM_W-1:0];
        state_nxt = S_TOT;
      end
      S_TOT: begin
        wsum_nxt  = (wsum_add > (SUM_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX : wsum_add[SUM_W-1:0];
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, now_r, wsum_r, tsum_r, (fin_cnt_r == load_cnt_r),
                           wt_r, tat_r, ct_r, fin_r, SLOT_OUT_W'(slot_r), ran_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      fin_cnt_r   <= '0;
      now_r       <= '0;
      tsum_r      <= '0;
      wsum_r      <= '0;
      issue_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      now_r       <= now_nxt;
      tsum_r      <= tsum_nxt;
      wsum_r      <= wsum_nxt;
      issue_r     <= issue_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    ran_r      <= ran_nxt;
    slot_r     <= slot_nxt;
    fin_r      <= fin_nxt;
    ct_r       <= ct_nxt;
    tat_r      <= tat_nxt;
    wt_r       <= wt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_fin_le_load: assert property (@(posedge clk) disable iff (!rst_n)
    fin_cnt_r <= load_cnt_r)
    else $error("finished count exceeds loaded count");

  a_load_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CW'(MAX_JOBS))
    else $error("loaded count exceeds table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted twice in a row");

  a_best_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) && best_found |-> (CW'(best_slot) < load_cnt_r))
    else $error("selected slot outside loaded table");
`endif

endmodule
